// ----- rtl/core/agcb_pkg.sv -----
// Package for the grid cell binning core: payload types, grid constants and the control store.
package agcb_pkg;

  localparam int unsigned GRID_X = 4;
  localparam int unsigned GRID_Y = 4;
  localparam int unsigned GRID_Z = 4;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SIZE_W = 31;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536000;

  localparam int unsigned UCODE_LEN = 33;
  localparam int unsigned PC_W = $clog2(UCODE_LEN);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_ORIGIN_Z    = 3'd2,
    CFG_CELL_SIZE_X = 3'd3,
    CFG_CELL_SIZE_Y = 3'd4,
    CFG_CELL_SIZE_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } box_t;

  typedef struct packed {
    logic [5:0] cell_index;
    logic [1:0] cell_x;
    logic [1:0] cell_y;
    logic [1:0] cell_z;
    logic       last_cell;
  } cell_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  // Quotient bit produced by one divider step; the top step only flags saturation.
  typedef enum logic [1:0] {
    DIV_SAT = 2'd0,
    DIV_B1  = 2'd1,
    DIV_B0  = 2'd2
  } div_bit_e;

  typedef enum logic [2:0] {
    OP_WAIT  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_DIV   = 3'd2,
    OP_STORE = 3'd3,
    OP_CHECK = 3'd4,
    OP_EMIT  = 3'd5
  } op_e;

  typedef struct packed {
    op_e             op;
    axis_e           axis;
    logic            hi;
    div_bit_e        dbit;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic     load;
    logic     step;
    div_bit_e dbit;
  } div_ctrl_t;

  // Clamp class of one truncated quotient: negative, saturated at four or above, or q.
  typedef struct packed {
    logic       neg;
    logic       sat;
    logic [1:0] q;
  } div_res_t;

  function automatic ucode_t uw(op_e op, axis_e axis, logic hi, div_bit_e dbit);
    ucode_t w;
    w.op     = op;
    w.axis   = axis;
    w.hi     = hi;
    w.dbit   = dbit;
    w.target = '0;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    w = uw(OP_WAIT, AX_X, 1'b0, DIV_SAT);
    unique case (pc)
      6'd0:  w = uw(OP_WAIT,  AX_X, 1'b0, DIV_SAT);
      6'd1:  w = uw(OP_LOAD,  AX_X, 1'b0, DIV_SAT);
      6'd2:  w = uw(OP_DIV,   AX_X, 1'b0, DIV_SAT);
      6'd3:  w = uw(OP_DIV,   AX_X, 1'b0, DIV_B1);
      6'd4:  w = uw(OP_DIV,   AX_X, 1'b0, DIV_B0);
      6'd5:  w = uw(OP_STORE, AX_X, 1'b0, DIV_SAT);
      6'd6:  w = uw(OP_LOAD,  AX_X, 1'b1, DIV_SAT);
      6'd7:  w = uw(OP_DIV,   AX_X, 1'b1, DIV_SAT);
      6'd8:  w = uw(OP_DIV,   AX_X, 1'b1, DIV_B1);
      6'd9:  w = uw(OP_DIV,   AX_X, 1'b1, DIV_B0);
      6'd10: w = uw(OP_STORE, AX_X, 1'b1, DIV_SAT);
      6'd11: w = uw(OP_LOAD,  AX_Y, 1'b0, DIV_SAT);
      6'd12: w = uw(OP_DIV,   AX_Y, 1'b0, DIV_SAT);
      6'd13: w = uw(OP_DIV,   AX_Y, 1'b0, DIV_B1);
      6'd14: w = uw(OP_DIV,   AX_Y, 1'b0, DIV_B0);
      6'd15: w = uw(OP_STORE, AX_Y, 1'b0, DIV_SAT);
      6'd16: w = uw(OP_LOAD,  AX_Y, 1'b1, DIV_SAT);
      6'd17: w = uw(OP_DIV,   AX_Y, 1'b1, DIV_SAT);
      6'd18: w = uw(OP_DIV,   AX_Y, 1'b1, DIV_B1);
      6'd19: w = uw(OP_DIV,   AX_Y, 1'b1, DIV_B0);
      6'd20: w = uw(OP_STORE, AX_Y, 1'b1, DIV_SAT);
      6'd21: w = uw(OP_LOAD,  AX_Z, 1'b0, DIV_SAT);
      6'd22: w = uw(OP_DIV,   AX_Z, 1'b0, DIV_SAT);
      6'd23: w = uw(OP_DIV,   AX_Z, 1'b0, DIV_B1);
      6'd24: w = uw(OP_DIV,   AX_Z, 1'b0, DIV_B0);
      6'd25: w = uw(OP_STORE, AX_Z, 1'b0, DIV_SAT);
      6'd26: w = uw(OP_LOAD,  AX_Z, 1'b1, DIV_SAT);
      6'd27: w = uw(OP_DIV,   AX_Z, 1'b1, DIV_SAT);
      6'd28: w = uw(OP_DIV,   AX_Z, 1'b1, DIV_B1);
      6'd29: w = uw(OP_DIV,   AX_Z, 1'b1, DIV_B0);
      6'd30: w = uw(OP_STORE, AX_Z, 1'b1, DIV_SAT);
      6'd31: w = uw(OP_CHECK, AX_X, 1'b0, DIV_SAT);
      6'd32: w = uw(OP_EMIT,  AX_X, 1'b0, DIV_SAT);
      default: w = uw(OP_WAIT, AX_X, 1'b0, DIV_SAT);
    endcase
    return w;
  endfunction

  // Upper index: clamp to the grid limit.
  function automatic logic [1:0] clamp_hi(div_res_t r, logic [1:0] lim);
    return (r.sat || (r.q > lim)) ? lim : r.q;
  endfunction

  // Lower index: clamp to the upper index, then to zero.
  function automatic logic [1:0] clamp_lo(div_res_t r, logic [1:0] hi);
    logic [1:0] v;
    v = (r.sat || (r.q > hi)) ? hi : r.q;
    return r.neg ? 2'd0 : v;
  endfunction

endpackage

// ----- rtl/core/agcb_div.sv -----
// Shared restoring divider: magnitude of a corner offset over the cell size, saturating at four.
module agcb_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  agcb_pkg::div_ctrl_t           ctrl_i,
  input  logic signed [32:0]            diff_i,
  input  logic [agcb_pkg::SIZE_W-1:0]   size_i,
  output agcb_pkg::div_res_t            res_o
);

  logic [32:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic        sat_q, sat_d;
  logic [1:0]  quo_q, quo_d;

  logic [agcb_pkg::SIZE_W-1:0] size_eff;
  logic [33:0] den;
  logic [33:0] diff_rem;
  logic        ge;

  assign size_eff = (size_i == '0) ? agcb_pkg::SIZE_W'(1) : size_i;

  always_comb begin
    unique case (ctrl_i.dbit)
      agcb_pkg::DIV_SAT: den = {1'b0, size_eff, 2'b00};
      agcb_pkg::DIV_B1:  den = {2'b00, size_eff, 1'b0};
      agcb_pkg::DIV_B0:  den = {3'b000, size_eff};
      default:           den = {3'b000, size_eff};
    endcase
  end

  assign diff_rem = {1'b0, rem_q} - den;
  assign ge = ({1'b0, rem_q} >= den);

  always_comb begin
    rem_d = rem_q;
    neg_d = neg_q;
    sat_d = sat_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      neg_d = diff_i[32];
      rem_d = diff_i[32] ? 33'(-diff_i) : 33'(diff_i);
      sat_d = 1'b0;
      quo_d = 2'd0;
    end else if (ctrl_i.step && ge) begin
      rem_d = diff_rem[32:0];
      unique case (ctrl_i.dbit)
        agcb_pkg::DIV_SAT: sat_d = 1'b1;
        agcb_pkg::DIV_B1:  quo_d[1] = 1'b1;
        agcb_pkg::DIV_B0:  quo_d[0] = 1'b1;
        default:           sat_d = sat_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
      sat_q <= 1'b0;
      quo_q <= 2'd0;
    end else begin
      neg_q <= neg_d;
      sat_q <= sat_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  // Truncation toward zero: a negative offset smaller than one cell gives index zero.
  assign res_o.neg = neg_q && (sat_q || (quo_q != 2'd0));
  assign res_o.sat = sat_q;
  assign res_o.q   = quo_q;

endmodule

// ----- rtl/core/aabb_grid_cell_binning_core.sv -----
// Top level of the grid cell binning core: control store sequencer, registers and cell walk.
//
// Bins one axis-aligned box (signed Q16.16 corners) into a 4x4x4 uniform grid and emits the
// flat index and coordinates of every covered cell, z outermost and x innermost, with
// last_cell set on the final one; a box whose upper index is below the grid on any axis
// gives no beats. Setup runs on the single shared divider, which a 33-step control program
// drives through six five-step divisions (load, three quotient steps, store) plus a range
// check; then one covered cell per cycle (1 to 64 cells) while the output is not stalled; the
// next box is taken once the last cell is in the output register. A cell size of zero acts as
// one LSB.
module aabb_grid_cell_binning_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  agcb_pkg::box_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output agcb_pkg::cell_t                     out_data_o,
  input  logic                                cfg_we_i,
  input  logic [agcb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [agcb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam logic [1:0] LIM_X = 2'(agcb_pkg::GRID_X - 1);
  localparam logic [1:0] LIM_Y = 2'(agcb_pkg::GRID_Y - 1);
  localparam logic [1:0] LIM_Z = 2'(agcb_pkg::GRID_Z - 1);

  logic signed [31:0]          origin_q [3];
  logic [agcb_pkg::SIZE_W-1:0] size_q [3];
  agcb_pkg::box_t              box_q;
  agcb_pkg::div_res_t          res_lo_q [3];
  agcb_pkg::div_res_t          res_hi_q [3];

  logic [agcb_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [1:0]                  cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic                        out_valid_q, out_valid_d;
  agcb_pkg::cell_t             out_q, out_d;

  agcb_pkg::ucode_t            uw;
  agcb_pkg::div_ctrl_t         div_ctrl;
  agcb_pkg::div_res_t          div_res;
  logic [1:0]                  ax_idx;
  logic signed [31:0]          corner;
  logic signed [32:0]          diff;
  logic [1:0]                  hx, hy, hz, lx, ly, lz;
  logic                        empty;
  logic                        last;
  logic                        out_free;
  logic                        in_accept;

  assign uw = agcb_pkg::ucode_rom(pc_q);
  assign ax_idx = uw.axis;

  always_comb begin
    unique case (uw.axis)
      agcb_pkg::AX_X: corner = uw.hi ? box_q.box_max_x : box_q.box_min_x;
      agcb_pkg::AX_Y: corner = uw.hi ? box_q.box_max_y : box_q.box_min_y;
      agcb_pkg::AX_Z: corner = uw.hi ? box_q.box_max_z : box_q.box_min_z;
      default:        corner = box_q.box_min_x;
    endcase
  end

  assign diff = {corner[31], corner} - {origin_q[ax_idx][31], origin_q[ax_idx]};

  assign div_ctrl.load = (uw.op == agcb_pkg::OP_LOAD);
  assign div_ctrl.step = (uw.op == agcb_pkg::OP_DIV);
  assign div_ctrl.dbit = uw.dbit;

  agcb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .diff_i (diff),
    .size_i (size_q[ax_idx]),
    .res_o  (div_res)
  );

  assign hx = agcb_pkg::clamp_hi(res_hi_q[0], LIM_X);
  assign hy = agcb_pkg::clamp_hi(res_hi_q[1], LIM_Y);
  assign hz = agcb_pkg::clamp_hi(res_hi_q[2], LIM_Z);
  assign lx = agcb_pkg::clamp_lo(res_lo_q[0], hx);
  assign ly = agcb_pkg::clamp_lo(res_lo_q[1], hy);
  assign lz = agcb_pkg::clamp_lo(res_lo_q[2], hz);
  assign empty = res_hi_q[0].neg || res_hi_q[1].neg || res_hi_q[2].neg;

  assign last = (cx_q == hx) && (cy_q == hy) && (cz_q == hz);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_accept = (uw.op == agcb_pkg::OP_WAIT) && in_valid_i;

  always_comb begin
    pc_d = pc_q;
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (uw.op)
      agcb_pkg::OP_WAIT: begin
        if (in_valid_i) pc_d = pc_q + 1'b1;
      end
      agcb_pkg::OP_CHECK: begin
        cx_d = lx;
        cy_d = ly;
        cz_d = lz;
        pc_d = empty ? uw.target : pc_q + 1'b1;
      end
      agcb_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.cell_index = 6'(cz_q) * 6'(agcb_pkg::GRID_X * agcb_pkg::GRID_Y)
                           + 6'(cy_q) * 6'(agcb_pkg::GRID_X) + 6'(cx_q);
          out_d.cell_x = cx_q;
          out_d.cell_y = cy_q;
          out_d.cell_z = cz_q;
          out_d.last_cell = last;
          if (last) begin
            pc_d = uw.target;
          end else if (cx_q != hx) begin
            cx_d = cx_q + 1'b1;
          end else begin
            cx_d = lx;
            if (cy_q != hy) begin
              cy_d = cy_q + 1'b1;
            end else begin
              cy_d = ly;
              cz_d = cz_q + 1'b1;
            end
          end
        end
      end
      default: pc_d = pc_q + 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        size_q[i] <= agcb_pkg::SIZE_RESET;
      end
    end else begin
      pc_q <= pc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          agcb_pkg::CFG_ORIGIN_X:    origin_q[0] <= cfg_data_i;
          agcb_pkg::CFG_ORIGIN_Y:    origin_q[1] <= cfg_data_i;
          agcb_pkg::CFG_ORIGIN_Z:    origin_q[2] <= cfg_data_i;
          agcb_pkg::CFG_CELL_SIZE_X: size_q[0] <= cfg_data_i[agcb_pkg::SIZE_W-1:0];
          agcb_pkg::CFG_CELL_SIZE_Y: size_q[1] <= cfg_data_i[agcb_pkg::SIZE_W-1:0];
          agcb_pkg::CFG_CELL_SIZE_Z: size_q[2] <= cfg_data_i[agcb_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;
    cy_q <= cy_d;
    cz_q <= cz_d;
    out_q <= out_d;
    if (in_accept) box_q <= in_data_i;
    if (uw.op == agcb_pkg::OP_STORE) begin
      if (uw.hi) res_hi_q[ax_idx] <= div_res;
      else       res_lo_q[ax_idx] <= div_res;
    end
  end

  assign in_stall_o  = (uw.op != agcb_pkg::OP_WAIT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
